FILE: rtl/core/lrast_pkg.sv
package lrast_pkg;

    // Field widths.
    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 8;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;

    // Operation codes carried in the op field of an input item.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic signed [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    // One input item.
    typedef struct packed {
        logic   op;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        color_t red;
        color_t green;
        color_t blue;
    } line_in_t;

    // One result item.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t out_red;
        color_t out_green;
        color_t out_blue;
        logic   last_pixel;
        logic   no_pixel;
    } line_out_t;

    // Item after line setup, as held in the input register.
    typedef struct packed {
        logic   op;
        coord_t first_x;
        coord_t first_y;
        coord_t orig_x;
        coord_t orig_y;
        coord_t end_x;
        coord_t end_y;
        color_t red;
        color_t green;
        color_t blue;
        delta_t delta_x;
        delta_t delta_y;
        logic   x_major;
        coord_t steps;
    } setup_t;

endpackage

FILE: rtl/core/lrast_setup.sv
module lrast_setup (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lrast_pkg::line_in_t s_data,
    output logic              setup_valid,
    input  logic              setup_ready,
    output lrast_pkg::setup_t setup_data
);
    import lrast_pkg::*;

    delta_t dx;
    delta_t dy;
    delta_t dx_neg;
    delta_t dy_neg;
    coord_t adx;
    coord_t ady;
    coord_t span;
    logic   swap;
    setup_t setup_next;
    logic   valid_reg;
    setup_t data_reg;

    // Deltas, walk direction and pixel count of a new line.
    // The walk is reversed exactly when the line falls in y.
    always_comb begin
        dx     = $signed({1'b0, s_data.x_end}) - $signed({1'b0, s_data.x_start});
        dy     = $signed({1'b0, s_data.y_end}) - $signed({1'b0, s_data.y_start});
        dx_neg = -dx;
        dy_neg = -dy;
        adx    = dx[DELTA_BITS-1] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady    = dy[DELTA_BITS-1] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        swap   = dy[DELTA_BITS-1];
        span   = (adx > ady) ? adx : ady;

        setup_next.op      = s_data.op;
        setup_next.first_x = s_data.x_start;
        setup_next.first_y = s_data.y_start;
        setup_next.orig_x  = swap ? s_data.x_end : s_data.x_start;
        setup_next.orig_y  = swap ? s_data.y_end : s_data.y_start;
        setup_next.end_x   = s_data.x_end;
        setup_next.end_y   = s_data.y_end;
        setup_next.red     = s_data.red;
        setup_next.green   = s_data.green;
        setup_next.blue    = s_data.blue;
        setup_next.delta_x = swap ? dx_neg : dx;
        setup_next.delta_y = $signed({1'b0, ady});
        setup_next.x_major = (adx >= ady);
        setup_next.steps   = (span != '0) ? (span - coord_t'(1)) : '0;
    end

    // Input register: takes a new item when it is empty or when the walker drains the current one.
    assign s_ready = !valid_reg || setup_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= setup_next;
        end
    end

    assign setup_valid = valid_reg;
    assign setup_data  = data_reg;

endmodule

FILE: rtl/core/lrast_walk.sv
module lrast_walk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 setup_valid,
    output logic                 setup_ready,
    input  lrast_pkg::setup_t    setup_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lrast_pkg::line_out_t m_data
);
    import lrast_pkg::*;

    logic      take;
    logic      active_reg, active_next;
    coord_t    walk_x_reg, walk_x_next;
    coord_t    walk_y_reg, walk_y_next;
    err_t      err_reg, err_next;
    err_t      inc_neg_reg, inc_neg_next;
    err_t      inc_pos_reg, inc_pos_next;
    logic      x_major_reg, x_major_next;
    logic      x_neg_reg, x_neg_next;
    coord_t    steps_reg, steps_next;
    coord_t    end_x_reg, end_x_next;
    coord_t    end_y_reg, end_y_next;
    color_t    red_reg, red_next;
    color_t    green_reg, green_next;
    color_t    blue_reg, blue_next;
    logic      m_valid_reg;
    line_out_t out_reg, out_next;

    err_t      ex;
    err_t      ey;
    err_t      mixed_inc;
    err_t      cross_inc;
    logic      start_x_neg;
    logic      err_negative;
    logic      move_x;
    logic      move_y;
    coord_t    step_x;
    coord_t    step_y;
    err_t      step_err;

    assign take        = setup_valid && setup_ready;
    assign setup_ready = !m_valid_reg || m_ready;

    // Error increments of a new line, one for each sign of the error term.
    always_comb begin
        ex = {{(ERR_BITS-DELTA_BITS){setup_data.delta_x[DELTA_BITS-1]}}, setup_data.delta_x};
        ey = {{(ERR_BITS-DELTA_BITS){setup_data.delta_y[DELTA_BITS-1]}}, setup_data.delta_y};
        start_x_neg = setup_data.delta_x[DELTA_BITS-1];
        mixed_inc   = start_x_neg ? (ey + ex) : (ey - ex);
        cross_inc   = start_x_neg ? ex : -ex;
    end

    // One step of the walk: the major axis always moves, the minor axis
    // moves when the error term says so.
    always_comb begin
        err_negative = err_reg[ERR_BITS-1];
        move_x   = x_major_reg || err_negative;
        move_y   = !x_major_reg || !err_negative;
        step_x   = move_x ? (x_neg_reg ? (walk_x_reg - coord_t'(1))
                                       : (walk_x_reg + coord_t'(1))) : walk_x_reg;
        step_y   = move_y ? (walk_y_reg + coord_t'(1)) : walk_y_reg;
        step_err = err_reg + (err_negative ? inc_neg_reg : inc_pos_reg);
    end

    // Next line state and result item for the item in the input register.
    always_comb begin
        active_next  = active_reg;
        walk_x_next  = walk_x_reg;
        walk_y_next  = walk_y_reg;
        err_next     = err_reg;
        inc_neg_next = inc_neg_reg;
        inc_pos_next = inc_pos_reg;
        x_major_next = x_major_reg;
        x_neg_next   = x_neg_reg;
        steps_next   = steps_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;

        out_next.pixel_x    = '0;
        out_next.pixel_y    = '0;
        out_next.out_red    = red_reg;
        out_next.out_green  = green_reg;
        out_next.out_blue   = blue_reg;
        out_next.last_pixel = 1'b0;
        out_next.no_pixel   = 1'b0;

        if (setup_data.op == OP_START) begin
            active_next  = 1'b1;
            walk_x_next  = setup_data.orig_x;
            walk_y_next  = setup_data.orig_y;
            err_next     = '0;
            inc_neg_next = setup_data.x_major ? ey : mixed_inc;
            inc_pos_next = setup_data.x_major ? mixed_inc : cross_inc;
            x_major_next = setup_data.x_major;
            x_neg_next   = start_x_neg;
            steps_next   = setup_data.steps;
            end_x_next   = setup_data.end_x;
            end_y_next   = setup_data.end_y;
            red_next     = setup_data.red;
            green_next   = setup_data.green;
            blue_next    = setup_data.blue;

            out_next.pixel_x   = setup_data.first_x;
            out_next.pixel_y   = setup_data.first_y;
            out_next.out_red   = setup_data.red;
            out_next.out_green = setup_data.green;
            out_next.out_blue  = setup_data.blue;
        end else if (!active_reg) begin
            // Advance with no line in progress.
            out_next.out_red   = '0;
            out_next.out_green = '0;
            out_next.out_blue  = '0;
            out_next.no_pixel  = 1'b1;
        end else if (steps_reg != '0) begin
            walk_x_next = step_x;
            walk_y_next = step_y;
            err_next    = step_err;
            steps_next  = steps_reg - coord_t'(1);

            out_next.pixel_x = step_x;
            out_next.pixel_y = step_y;
        end else begin
            // Second endpoint closes the line.
            active_next = 1'b0;

            out_next.pixel_x    = end_x_reg;
            out_next.pixel_y    = end_y_reg;
            out_next.last_pixel = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                active_reg <= active_next;
            end
            if (setup_ready) begin
                m_valid_reg <= setup_valid;
            end
        end
    end

    // Line state and result register.
    always_ff @(posedge aclk) begin
        if (take) begin
            walk_x_reg  <= walk_x_next;
            walk_y_reg  <= walk_y_next;
            err_reg     <= err_next;
            inc_neg_reg <= inc_neg_next;
            inc_pos_reg <= inc_pos_next;
            x_major_reg <= x_major_next;
            x_neg_reg   <= x_neg_next;
            steps_reg   <= steps_next;
            end_x_reg   <= end_x_next;
            end_y_reg   <= end_y_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            out_reg     <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // An item taken from the input register always lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("taken item did not reach the result register");

    // An interior step counts the remaining pixels down by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && setup_data.op == OP_ADVANCE && active_reg && steps_reg != '0)
        |=> (steps_reg == $past(steps_reg) - coord_t'(1)) && active_reg)
        else $error("interior step did not count down");

    // The endpoint pixel ends the line and is flagged last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && setup_data.op == OP_ADVANCE && active_reg && steps_reg == '0)
        |=> !active_reg && out_reg.last_pixel && !out_reg.no_pixel)
        else $error("endpoint did not close the line");

    // A no-pixel result carries no coordinates, color or last flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.no_pixel)
        |-> (out_reg.pixel_x == '0) && (out_reg.pixel_y == '0) && !out_reg.last_pixel
            && (out_reg.out_red == '0) && (out_reg.out_green == '0)
            && (out_reg.out_blue == '0))
        else $error("no-pixel result carries data");

endmodule

FILE: rtl/core/line_rasterizer_unit.sv
// Line rasterizer. A start item (op = start) latches two endpoints and a color
// and returns the first endpoint; each advance item returns the next pixel of
// the line, the second endpoint being flagged last_pixel, and advances after
// that return no_pixel. Exactly one result item comes back for every input
// item, in order. The block takes one item per clock cycle when the result
// side is ready; an accepted item passes through the setup register (deltas,
// walk direction, pixel count) and then the walker's result register (one
// error update and one coordinate step). Coordinates wrap at the coordinate
// width.
module line_rasterizer_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lrast_pkg::line_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lrast_pkg::line_out_t m_data
);
    import lrast_pkg::*;

    logic   setup_valid;
    logic   setup_ready;
    setup_t setup_data;

    // Input register with per-line setup.
    lrast_setup u_setup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .setup_valid (setup_valid),
        .setup_ready (setup_ready),
        .setup_data  (setup_data)
    );

    // Line walker and result register.
    lrast_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .setup_valid (setup_valid),
        .setup_ready (setup_ready),
        .setup_data  (setup_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
